### src/running_key_byte_cipher_stats_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef RUNNING_KEY_BYTE_CIPHER_STATS_ASSERT_SVH
`define RUNNING_KEY_BYTE_CIPHER_STATS_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RKBCS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rkbcs assertion failed");

// Check a property on every clock edge, reset included.
`define RKBCS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rkbcs reset assertion failed");

`endif

### src/rkbcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rkbcs_pkg;

  // Key table geometry
  localparam int unsigned KEY_DEPTH = 1024;
  localparam int unsigned POS_W     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(KEY_DEPTH + 1);

  // Symbol and statistics widths
  localparam int unsigned SYM_W      = 7;
  localparam int unsigned NUM_SYMS   = 128;
  localparam int unsigned CODE_W     = 7;
  localparam int unsigned STAT_CNT_W = 32;
  localparam int unsigned VAR_W      = 8;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 64;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_ENCODE  = 2'd1,
    KIND_DECODE  = 2'd2,
    KIND_RESTART = 2'd3
  } kind_e;

  // Classified item handed from front to back
  typedef struct packed {
    logic              stat;
    logic              err;
    logic [CODE_W-1:0] res;
    logic [SYM_W-1:0]  sym;
  } q_item_t;

  // Result beat, lowest field in the lowest bits
  typedef struct packed {
    logic [1:0]            pad;
    logic [CODE_W-1:0]     max_code;
    logic [CODE_W-1:0]     min_code;
    logic [VAR_W-1:0]      variant_count;
    logic [STAT_CNT_W-1:0] symbol_count;
    logic                  error;
    logic [CODE_W-1:0]     result_byte;
  } out_t;

endpackage

`default_nettype wire

### src/rkbcs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rkbcs_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_valid_i,
  output logic                                      s_ready_o,
  input  wire logic [1:0]                           s_kind_i,
  input  wire logic [7:0]                           s_byte_i,
  input  wire logic [rkbcs_pkg::CODE_W-1:0]         s_key_i,
  input  wire logic [rkbcs_pkg::QCNT_W-1:0]         q_cnt_i,
  output logic                                      push_o,
  output rkbcs_pkg::q_item_t                        push_item_o
);

  localparam int unsigned POS_W  = rkbcs_pkg::POS_W;
  localparam int unsigned CNT_W  = rkbcs_pkg::CNT_W;
  localparam int unsigned CODE_W = rkbcs_pkg::CODE_W;
  localparam int unsigned SUM_W  = rkbcs_pkg::QCNT_W + 1;

  logic [CODE_W-1:0] key_mem [rkbcs_pkg::KEY_DEPTH];
  logic [CODE_W-1:0] key_rd_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] addr;
  logic [CNT_W-1:0] addr_inc;
  logic             accept;
  logic             err;
  logic             wr_en;
  logic             rd_en;

  logic                 s1_valid_q;
  rkbcs_pkg::kind_e     s1_kind_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_err_q;
  logic [CODE_W-1:0]    enc_res;
  logic [CODE_W-1:0]    dec_res;
  rkbcs_pkg::kind_e     kind;

  // Credit check: the queue must hold every item in flight
  assign s_ready_o = (SUM_W'(q_cnt_i) + SUM_W'(s1_valid_q)) < SUM_W'(rkbcs_pkg::QDEPTH);
  assign accept    = s_valid_i && s_ready_o;
  assign kind      = rkbcs_pkg::kind_e'(s_kind_i);

  // Classify the beat and advance key count and position
  always_comb begin
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    err      = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    addr     = (CNT_W'(pos_q) >= cnt_q) ? '0 : pos_q;
    addr_inc = CNT_W'(addr) + CNT_W'(1);
    case (kind)
      rkbcs_pkg::KIND_LOAD: begin
        if (cnt_q >= CNT_W'(rkbcs_pkg::KEY_DEPTH)) begin
          err = 1'b1;
        end else begin
          wr_en = accept;
          if (accept) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      rkbcs_pkg::KIND_RESTART: begin
        if (accept) begin
          pos_d = '0;
        end
      end
      rkbcs_pkg::KIND_ENCODE, rkbcs_pkg::KIND_DECODE: begin
        if (cnt_q == '0) begin
          err = 1'b1;
        end else begin
          rd_en = accept;
          if (accept) begin
            pos_d = (addr_inc >= cnt_q) ? '0 : addr_inc[POS_W-1:0];
          end
        end
      end
      default: begin
        err = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      s1_valid_q <= accept;
    end
  end

  // Hold the beat while the key is read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= kind;
      s1_byte_q <= s_byte_i;
      s1_err_q  <= err;
    end
  end

  // Key table: append on load, registered read on transform
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[cnt_q[POS_W-1:0]] <= s_key_i;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[addr];
    end
  end

  // Apply the key and push to the queue
  assign enc_res = s1_byte_q[CODE_W-1:0] + key_rd_q;
  assign dec_res = s1_byte_q[CODE_W-1:0] - key_rd_q;

  always_comb begin
    push_item_o.stat = 1'b0;
    push_item_o.err  = s1_err_q;
    push_item_o.res  = '0;
    push_item_o.sym  = s1_byte_q[CODE_W-1:0];
    case (s1_kind_q)
      rkbcs_pkg::KIND_ENCODE: begin
        if (!s1_err_q) begin
          push_item_o.stat = 1'b1;
          push_item_o.res  = enc_res;
        end
      end
      rkbcs_pkg::KIND_DECODE: begin
        if (!s1_err_q) begin
          push_item_o.res = dec_res;
        end
      end
      default: begin
        push_item_o.res = '0;
      end
    endcase
  end

  assign push_o = s1_valid_q;

endmodule

`default_nettype wire

### src/rkbcs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rkbcs_queue (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire rkbcs_pkg::q_item_t           push_item_i,
  input  wire logic                         pop_i,
  output rkbcs_pkg::q_item_t                pop_item_o,
  output logic                              not_empty_o,
  output logic [rkbcs_pkg::QCNT_W-1:0]      cnt_o
);

  localparam int unsigned QPTR_W = rkbcs_pkg::QPTR_W;
  localparam int unsigned QCNT_W = rkbcs_pkg::QCNT_W;

  rkbcs_pkg::q_item_t slots_q [rkbcs_pkg::QDEPTH];

  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign do_pop      = pop_i && (cnt_q != '0);
  assign not_empty_o = (cnt_q != '0);
  assign cnt_o       = cnt_q;
  assign pop_item_o  = slots_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(rkbcs_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(rkbcs_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### src/rkbcs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rkbcs_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               q_valid_i,
  input  wire rkbcs_pkg::q_item_t                 q_item_i,
  output logic                                    pop_o,
  output logic                                    m_valid_o,
  input  wire logic                               m_ready_i,
  output logic [rkbcs_pkg::OUT_DATA_W-1:0]        m_data_o
);

  localparam int unsigned SYM_W  = rkbcs_pkg::SYM_W;
  localparam int unsigned CODE_W = rkbcs_pkg::CODE_W;
  localparam int unsigned CNT_W  = rkbcs_pkg::STAT_CNT_W;
  localparam int unsigned VAR_W  = rkbcs_pkg::VAR_W;
  localparam int unsigned NSYM   = rkbcs_pkg::NUM_SYMS;

  // Statistics stores, one entry per symbol
  logic [CNT_W-1:0]  cnt_mem  [NSYM];
  logic [NSYM-1:0]   seen_mem [NSYM];
  logic [VAR_W-1:0]  dist_mem [NSYM];
  logic [CODE_W-1:0] lo_mem   [NSYM];
  logic [CODE_W-1:0] hi_mem   [NSYM];
  logic [NSYM-1:0]   vld_q;

  logic [CNT_W-1:0]  cnt_rd_q, fwd_cnt_q, old_cnt, new_cnt;
  logic [NSYM-1:0]   seen_rd_q, fwd_seen_q, old_seen, new_seen;
  logic [VAR_W-1:0]  dist_rd_q, fwd_dist_q, old_dist, new_dist;
  logic [CODE_W-1:0] lo_rd_q, fwd_lo_q, old_lo, new_lo;
  logic [CODE_W-1:0] hi_rd_q, fwd_hi_q, old_hi, new_hi;
  logic              vld_rd_q;
  logic              fwd_sel_q;

  logic               e_valid_q;
  rkbcs_pkg::q_item_t e_item_q;
  logic               e_fire;
  logic               e_load;
  logic               wr_en;
  logic [SYM_W-1:0]   sym_rd;
  logic [CODE_W-1:0]  code;

  logic            m_valid_q;
  rkbcs_pkg::out_t out_q, out_d;

  // Execute advances when the output register is free or drains
  assign e_fire = e_valid_q && (!m_valid_q || m_ready_i);
  assign e_load = q_valid_i && (!e_valid_q || e_fire);
  assign pop_o  = e_load;
  assign wr_en  = e_fire && e_item_q.stat;
  assign sym_rd = q_item_i.sym;
  assign code   = e_item_q.res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      if (e_load) begin
        e_valid_q <= 1'b1;
      end else if (e_fire) begin
        e_valid_q <= 1'b0;
      end
      if (e_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      if (wr_en) begin
        vld_q[e_item_q.sym] <= 1'b1;
      end
    end
  end

  // Read stores on entry; forward the update that lands in the same cycle
  always_ff @(posedge clk_i) begin
    if (e_load) begin
      e_item_q   <= q_item_i;
      cnt_rd_q   <= cnt_mem[sym_rd];
      seen_rd_q  <= seen_mem[sym_rd];
      dist_rd_q  <= dist_mem[sym_rd];
      lo_rd_q    <= lo_mem[sym_rd];
      hi_rd_q    <= hi_mem[sym_rd];
      vld_rd_q   <= vld_q[sym_rd];
      fwd_sel_q  <= wr_en && (e_item_q.sym == sym_rd);
      fwd_cnt_q  <= new_cnt;
      fwd_seen_q <= new_seen;
      fwd_dist_q <= new_dist;
      fwd_lo_q   <= new_lo;
      fwd_hi_q   <= new_hi;
    end
    if (wr_en) begin
      cnt_mem[e_item_q.sym]  <= new_cnt;
      seen_mem[e_item_q.sym] <= new_seen;
      dist_mem[e_item_q.sym] <= new_dist;
      lo_mem[e_item_q.sym]   <= new_lo;
      hi_mem[e_item_q.sym]   <= new_hi;
    end
  end

  // Pick current statistics: forwarded, stored, or reset value
  always_comb begin
    if (fwd_sel_q) begin
      old_cnt  = fwd_cnt_q;
      old_seen = fwd_seen_q;
      old_dist = fwd_dist_q;
      old_lo   = fwd_lo_q;
      old_hi   = fwd_hi_q;
    end else if (vld_rd_q) begin
      old_cnt  = cnt_rd_q;
      old_seen = seen_rd_q;
      old_dist = dist_rd_q;
      old_lo   = lo_rd_q;
      old_hi   = hi_rd_q;
    end else begin
      old_cnt  = '0;
      old_seen = '0;
      old_dist = '0;
      old_lo   = '1;
      old_hi   = '0;
    end
  end

  // Update: saturating count, first sighting of a code widens the range
  always_comb begin
    new_cnt  = (&old_cnt) ? old_cnt : old_cnt + CNT_W'(1);
    new_seen = old_seen;
    new_dist = old_dist;
    new_lo   = old_lo;
    new_hi   = old_hi;
    if (!old_seen[code]) begin
      new_seen = old_seen | (NSYM'(1) << code);
      new_dist = old_dist + VAR_W'(1);
      new_lo   = (code < old_lo) ? code : old_lo;
      new_hi   = (code > old_hi) ? code : old_hi;
    end
  end

  // Build the result beat
  always_comb begin
    out_d             = '0;
    out_d.result_byte = e_item_q.res;
    out_d.error       = e_item_q.err;
    if (e_item_q.stat) begin
      out_d.symbol_count  = new_cnt;
      out_d.variant_count = new_dist;
      out_d.min_code      = new_lo;
      out_d.max_code      = new_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      out_q <= out_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = out_q;

endmodule

`default_nettype wire

### src/running_key_byte_cipher_stats.sv
// Throughput: one beat per cycle sustained while the output is not
// stalled; the key table read port and the one-read/one-write
// statistics stores each take one access per cycle.
// Reset: counters, key position, queue and valid flags clear at once; the
// statistics read as their reset values until written, no clearing pass.
// The key table holds no value until loaded.
`timescale 1ns / 1ps
`default_nettype none

module running_key_byte_cipher_stats (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // data_byte[7:0], key_value[14:8], zero[15]
  input  wire logic [rkbcs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind[1:0]
  input  wire logic [rkbcs_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // result_byte[6:0], error[7], symbol_count[39:8], variant_count[47:40],
  // min_code[54:48], max_code[61:55], zero[63:62]
  output logic [rkbcs_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

  logic                             push;
  rkbcs_pkg::q_item_t               push_item;
  logic                             pop;
  rkbcs_pkg::q_item_t               pop_item;
  logic                             q_not_empty;
  logic [rkbcs_pkg::QCNT_W-1:0]     q_cnt;

  rkbcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_kind_i    (s_axis_tuser),
    .s_byte_i    (s_axis_tdata[7:0]),
    .s_key_i     (s_axis_tdata[14:8]),
    .q_cnt_i     (q_cnt),
    .push_o      (push),
    .push_item_o (push_item)
  );

  rkbcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .not_empty_o (q_not_empty),
    .cnt_o       (q_cnt)
  );

  rkbcs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_not_empty),
    .q_item_i  (pop_item),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### src/rkbcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "running_key_byte_cipher_stats_assert.svh"

module rkbcs_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic [rkbcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  logic        out_v;
  logic        out_stall;
  logic        out_err;
  logic [6:0]  out_res;
  logic [53:0] out_stats;
  logic [31:0] out_cnt;
  logic [7:0]  out_var;
  logic [6:0]  out_lo;
  logic [6:0]  out_hi;
  logic        var_ok;

  // Split the result beat into its fields
  assign out_v     = m_axis_tvalid;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_res   = m_axis_tdata[6:0];
  assign out_err   = m_axis_tdata[7];
  assign out_stats = m_axis_tdata[61:8];
  assign out_cnt   = m_axis_tdata[39:8];
  assign out_var   = m_axis_tdata[47:40];
  assign out_lo    = m_axis_tdata[54:48];
  assign out_hi    = m_axis_tdata[61:55];
  assign var_ok    = (out_var <= 8'd128) && (out_cnt != '0 || out_var == '0);

  // A stalled result beat holds
  `RKBCS_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_v && $stable(m_axis_tdata))

  // An error beat carries no result and no statistics
  `RKBCS_ASSERT(a_err_zero, clk_i, rst_ni, out_v && out_err |-> out_res == '0 && out_stats == '0)

  // Distinct codes never exceed the code space and are zero while the symbol count is zero
  `RKBCS_ASSERT(a_var_bound, clk_i, rst_ni, out_v |-> var_ok)

  // A symbol with codes seen has an ordered code range
  `RKBCS_ASSERT(a_range_order, clk_i, rst_ni, out_v && out_var != '0 |-> out_lo <= out_hi)

  // No result beat while in reset
  `RKBCS_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_v)

endmodule

bind running_key_byte_cipher_stats rkbcs_checker u_rkbcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/tb_running_key_byte_cipher_stats.sv
`timescale 1ns / 1ps

module tb_running_key_byte_cipher_stats;

  localparam int unsigned MAX_CYCLES   = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_REPORTS  = 100;

  localparam int unsigned IN_DATA_W  = rkbcs_pkg::IN_DATA_W;
  localparam int unsigned IN_USER_W  = rkbcs_pkg::IN_USER_W;
  localparam int unsigned OUT_DATA_W = rkbcs_pkg::OUT_DATA_W;
  localparam int unsigned CODE_W     = rkbcs_pkg::CODE_W;
  localparam int unsigned KEY_DEPTH  = rkbcs_pkg::KEY_DEPTH;
  localparam int unsigned NUM_SYMS   = rkbcs_pkg::NUM_SYMS;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // data_byte[7:0], key_value[14:8], zero[15]
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // kind[1:0]
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // result_byte[6:0], error[7], symbol_count[39:8], variant_count[47:40],
  // min_code[54:48], max_code[61:55], zero[63:62]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  running_key_byte_cipher_stats u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the cipher state, advanced on every accepted input beat
  logic [CODE_W-1:0]     key_mem [KEY_DEPTH];
  int unsigned           keys_loaded;
  int unsigned           key_idx;
  logic [31:0]           sym_hits      [NUM_SYMS];
  logic [127:0]          sym_code_seen [NUM_SYMS];
  logic [7:0]            sym_variants  [NUM_SYMS];
  logic [CODE_W-1:0]     sym_lo        [NUM_SYMS];
  logic [CODE_W-1:0]     sym_hi        [NUM_SYMS];

  rkbcs_pkg::out_t pending_results [$];
  int unsigned     mismatches;
  int unsigned     results_checked;
  int unsigned     n_load, n_encode, n_decode, n_restart, n_error;
  int unsigned     peak_variants;
  bit              steady_flow;

  function automatic void clear_cipher_state();
    keys_loaded = 0;
    key_idx     = 0;
    for (int i = 0; i < NUM_SYMS; i++) begin
      sym_hits[i]      = '0;
      sym_code_seen[i] = '0;
      sym_variants[i]  = '0;
      sym_lo[i]        = '1;
      sym_hi[i]        = '0;
    end
  endfunction

  // Work out the result beat of one input beat and advance the shadow state
  function automatic rkbcs_pkg::out_t cipher_predict(rkbcs_pkg::kind_e kind,
                                                     logic [7:0] data_byte,
                                                     logic [6:0] key_value);
    rkbcs_pkg::out_t   r;
    logic [CODE_W-1:0] key;
    logic [CODE_W-1:0] sym;
    logic [CODE_W-1:0] code;
    logic [7:0]        sum;
    r = '0;
    case (kind)
      rkbcs_pkg::KIND_LOAD: begin
        if (keys_loaded >= KEY_DEPTH) begin
          r.error = 1'b1;
        end else begin
          key_mem[keys_loaded] = key_value;
          keys_loaded++;
        end
      end
      rkbcs_pkg::KIND_RESTART: begin
        key_idx = 0;
      end
      default: begin
        if (keys_loaded == 0) begin
          r.error = 1'b1;
        end else begin
          if (key_idx >= keys_loaded) key_idx = 0;
          key     = key_mem[key_idx];
          key_idx = (key_idx + 1 >= keys_loaded) ? 0 : key_idx + 1;
          if (kind == rkbcs_pkg::KIND_DECODE) begin
            sum           = data_byte - {1'b0, key};
            r.result_byte = sum[6:0];
          end else begin
            sum           = data_byte + {1'b0, key};
            code          = sum[6:0];
            sym           = data_byte[6:0];
            r.result_byte = code;
            if (sym_hits[sym] != '1) sym_hits[sym]++;
            // first time this code shows up for the symbol
            if (!sym_code_seen[sym][code]) begin
              sym_code_seen[sym][code] = 1'b1;
              sym_variants[sym]++;
              if (code < sym_lo[sym]) sym_lo[sym] = code;
              if (code > sym_hi[sym]) sym_hi[sym] = code;
            end
            r.symbol_count  = sym_hits[sym];
            r.variant_count = sym_variants[sym];
            r.min_code      = sym_lo[sym];
            r.max_code      = sym_hi[sym];
            if (sym_variants[sym] > peak_variants) peak_variants = sym_variants[sym];
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk_i) begin : result_check
    rkbcs_pkg::out_t want;
    rkbcs_pkg::out_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        case (rkbcs_pkg::kind_e'(s_axis_tuser))
          rkbcs_pkg::KIND_LOAD:    n_load++;
          rkbcs_pkg::KIND_ENCODE:  n_encode++;
          rkbcs_pkg::KIND_DECODE:  n_decode++;
          default:                 n_restart++;
        endcase
        pending_results.push_back(cipher_predict(rkbcs_pkg::kind_e'(s_axis_tuser),
                                                 s_axis_tdata[7:0], s_axis_tdata[14:8]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = rkbcs_pkg::out_t'(m_axis_tdata);
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t ns: result beat expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.error) n_error++;
          check_field("result_byte",   want.result_byte,   got.result_byte);
          check_field("error",         want.error,         got.error);
          check_field("symbol_count",  want.symbol_count,  got.symbol_count);
          check_field("variant_count", want.variant_count, got.variant_count);
          check_field("min_code",      want.min_code,      got.min_code);
          check_field("max_code",      want.max_code,      got.max_code);
        end
      end
    end
  end

  // Result side: random stall before each beat, none in steady stretches
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Abort a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t ns: cycle limit reached, %0d results outstanding", $time,
             pending_results.size());
    $display("tb_running_key_byte_cipher_stats: done, errors");
    $finish;
  end

  // Hold valid through back-to-back beats, drop it only ahead of a gap
  task automatic send_beat(rkbcs_pkg::kind_e kind, logic [7:0] data_byte,
                           logic [6:0] key_value);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, key_value, data_byte};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending until every expected result beat is back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_transform();
    send_beat(($urandom_range(0, 1) != 0) ? rkbcs_pkg::KIND_ENCODE : rkbcs_pkg::KIND_DECODE,
              8'($urandom), 7'($urandom));
  endtask

  // Empty table, field extremes, wrap of the position, loads mid-stream
  task automatic test_directed();
    send_beat(rkbcs_pkg::KIND_ENCODE,  8'h00, 7'h7F);
    send_beat(rkbcs_pkg::KIND_DECODE,  8'hFF, 7'h00);
    send_beat(rkbcs_pkg::KIND_RESTART, 8'hA5, 7'h2A);
    send_beat(rkbcs_pkg::KIND_LOAD,    8'hFF, 7'h00);
    send_beat(rkbcs_pkg::KIND_LOAD,    8'h00, 7'h7F);
    send_beat(rkbcs_pkg::KIND_LOAD,    8'h3C, 7'h55);
    send_beat(rkbcs_pkg::KIND_ENCODE,  8'h00, 7'h00);
    send_beat(rkbcs_pkg::KIND_ENCODE,  8'hFF, 7'h7F);
    send_beat(rkbcs_pkg::KIND_ENCODE,  8'h80, 7'h00);
    send_beat(rkbcs_pkg::KIND_DECODE,  8'h00, 7'h7F);
    send_beat(rkbcs_pkg::KIND_DECODE,  8'hFF, 7'h00);
    send_beat(rkbcs_pkg::KIND_RESTART, 8'h00, 7'h00);
    send_beat(rkbcs_pkg::KIND_ENCODE,  8'h7F, 7'h7F);
    send_beat(rkbcs_pkg::KIND_DECODE,  8'h80, 7'h00);
    send_beat(rkbcs_pkg::KIND_LOAD,    8'h00, 7'h01);
    send_beat(rkbcs_pkg::KIND_ENCODE,  8'h01, 7'h00);
    send_beat(rkbcs_pkg::KIND_ENCODE,  8'h01, 7'h00);
    send_beat(rkbcs_pkg::KIND_ENCODE,  8'h01, 7'h00);
    send_beat(rkbcs_pkg::KIND_ENCODE,  8'h7F, 7'h00);
    send_beat(rkbcs_pkg::KIND_RESTART, 8'hFF, 7'h7F);
    send_beat(rkbcs_pkg::KIND_DECODE,  8'h7F, 7'h55);
  endtask

  // Load every key value once, then drive one symbol through all 128 codes
  task automatic test_all_codes();
    logic [6:0]  perm [128];
    logic [6:0]  tmp;
    logic [6:0]  sym;
    int unsigned j;
    for (int i = 0; i < 128; i++) perm[i] = 7'(i);
    for (int i = 127; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < 128; i++) send_beat(rkbcs_pkg::KIND_LOAD, 8'($urandom), perm[i]);
    send_beat(rkbcs_pkg::KIND_RESTART, 8'($urandom), 7'($urandom));
    sym = 7'($urandom);
    for (int i = 0; i < 136; i++) begin
      steady_flow = (i < 40);
      send_beat(rkbcs_pkg::KIND_ENCODE, {1'($urandom), sym}, 7'($urandom));
    end
    steady_flow = 1'b0;
  endtask

  // Mixed traffic, biased toward a few symbols so statistics build up
  task automatic test_random_mix(int unsigned n);
    int unsigned pick;
    logic [7:0]  data_byte;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      data_byte = ($urandom_range(0, 1) != 0) ? 8'($urandom)
                                              : {1'($urandom), 7'($urandom_range(0, 7))};
      pick = $urandom_range(0, 99);
      if (pick < 8)       send_beat(rkbcs_pkg::KIND_LOAD,    data_byte, 7'($urandom));
      else if (pick < 50) send_beat(rkbcs_pkg::KIND_ENCODE,  data_byte, 7'($urandom));
      else if (pick < 88) send_beat(rkbcs_pkg::KIND_DECODE,  data_byte, 7'($urandom));
      else                send_beat(rkbcs_pkg::KIND_RESTART, data_byte, 7'($urandom));
    end
    steady_flow = 1'b0;
  endtask

  // Fill the key table to the top, then push loads into the full table
  task automatic test_fill_table();
    int unsigned needed;
    wait_idle();
    needed = KEY_DEPTH - keys_loaded;
    for (int i = 0; i < needed; i++) begin
      send_beat(rkbcs_pkg::KIND_LOAD, 8'($urandom), 7'($urandom));
      if (i % 16 == 15) send_random_transform();
    end
    send_beat(rkbcs_pkg::KIND_LOAD, 8'h00, 7'h7F);
    send_beat(rkbcs_pkg::KIND_LOAD, 8'hFF, 7'h00);
    for (int i = 0; i < 4; i++) send_beat(rkbcs_pkg::KIND_LOAD, 8'($urandom), 7'($urandom));
    send_beat(rkbcs_pkg::KIND_RESTART, 8'($urandom), 7'($urandom));
  endtask

  // Walk the position past the last entry of a full table
  task automatic test_full_wrap();
    for (int i = 0; i < 1030; i++) begin
      if (i % 128 == 0) steady_flow = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 49) == 0) begin
        send_beat(rkbcs_pkg::KIND_LOAD, 8'($urandom), 7'($urandom));
      end
      send_random_transform();
    end
    steady_flow = 1'b0;
    send_beat(rkbcs_pkg::KIND_RESTART, 8'($urandom), 7'($urandom));
    send_random_transform();
    send_random_transform();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= rkbcs_pkg::KIND_LOAD;
    steady_flow   = 1'b0;
    mismatches    = 0;
    results_checked = 0;
    n_load = 0; n_encode = 0; n_decode = 0; n_restart = 0; n_error = 0;
    peak_variants = 0;
    clear_cipher_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_all_codes();
    wait_idle();
    test_random_mix(100);
    test_fill_table();
    test_full_wrap();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d results: %0d loads, %0d encodes, %0d decodes, %0d restarts",
             results_checked, n_load, n_encode, n_decode, n_restart);
    $display("%0d error results, %0d keys loaded, peak distinct codes per symbol %0d",
             n_error, keys_loaded, peak_variants);
    if (mismatches == 0) begin
      $display("tb_running_key_byte_cipher_stats: done, clean");
    end else begin
      $display("tb_running_key_byte_cipher_stats: done, errors");
    end
    $finish;
  end

endmodule
